### rtl/core/sam_pkg.sv
`default_nettype none

package sam_pkg;

  localparam int unsigned TRIG_FRAC_DEF = 14;
  localparam int unsigned CORDIC_STEPS  = 24;

  // CORDIC datapath widths: x/y in Q.30 with headroom, z in 2^-32 turns
  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 32;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // stage map: input reg, CORDIC steps, round, multiply, sum, output
  localparam int unsigned STG_R      = CORDIC_STEPS + 1;
  localparam int unsigned STG_P      = CORDIC_STEPS + 2;
  localparam int unsigned STG_A      = CORDIC_STEPS + 3;
  localparam int unsigned STG_O      = CORDIC_STEPS + 4;
  localparam int unsigned NUM_STAGES = CORDIC_STEPS + 5;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [11:0]        width;
    logic [11:0]        height;
  } sprite_t;

  typedef struct packed {
    logic signed [31:0] m_a;
    logic signed [31:0] m_b;
    logic signed [31:0] m_c;
    logic signed [31:0] m_d;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
  } result_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933405;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10679838;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335086;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41721;
      5'd15:   v = 32'sd20860;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2607;
      5'd19:   v = 32'sd1303;
      5'd20:   v = 32'sd651;
      5'd21:   v = 32'sd325;
      5'd22:   v = 32'sd162;
      5'd23:   v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sprite_affine_matrix.sv
// Sprite affine matrix: one sprite in (pos_x, pos_y, width, height, angle),
// one set of 2D model-matrix terms out (m_a..m_d in Q.14, trans_x/trans_y
// in Q.8, all saturated to 32 bits). The rotation is about the sprite's
// center; sine and cosine come from a 24-step CORDIC.
//
// Both channels are valid/ready; an item moves when valid and ready are high
// at a rising edge. One item is taken per cycle while in_ready is high. An
// accepted item passes the input register, the 24 CORDIC stages, the
// rounding, multiply, sum and saturation stages and the output register
// before out_valid rises.
//
// When the receiver stalls, the output register holds its item and one more
// item from the pipeline drops into a skid register; only then does in_ready
// fall and the whole pipeline freeze. Items in flight are kept, never dropped
// or repeated. Reset (synchronous, active high) empties the pipeline, output
// and skid register; in_ready is high right after.
`default_nettype none

module sprite_affine_matrix
  import sam_pkg::*;
#(
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic [11:0]        width,
  input  wire logic [11:0]        height,
  input  wire logic [15:0]        angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      m_a,
  output logic signed [31:0]      m_b,
  output logic signed [31:0]      m_c,
  output logic signed [31:0]      m_d,
  output logic signed [31:0]      trans_x,
  output logic signed [31:0]      trans_y
);

  localparam int unsigned F       = TRIG_FRAC_BITS;
  localparam int unsigned TRIG_SH = 30 - F;
  localparam int unsigned CW      = F + 2;
  localparam int unsigned PW      = CW + 13;
  localparam int unsigned DN      = (F > 14) ? F - 14 : 0;
  localparam int unsigned UP      = (F < 14) ? 14 - F : 0;
  localparam int unsigned TW      = PW + 1 + UP;
  localparam int unsigned SW      = F + 27;

  localparam logic signed [XW-1:0] TRIG_RND = XW'(64'd1 << (TRIG_SH - 1));
  localparam logic signed [TW-1:0] TERM_RND = TW'((64'd1 << DN) >> 1);
  localparam logic signed [SW-1:0] TRANS_RND = SW'(64'd1 << F);

  logic [NUM_STAGES-1:0] vld;
  logic                  en;
  logic                  ov;
  logic                  sv;

  logic signed [XW-1:0] cx   [0:CORDIC_STEPS];
  logic signed [XW-1:0] cy   [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cz   [0:CORDIC_STEPS];
  logic [1:0]           quad [0:CORDIC_STEPS];
  sprite_t              side [0:STG_P];

  logic signed [CW-1:0] tc, ts;
  logic signed [PW-1:0] p_wc, p_ws, p_hs, p_hc;
  logic signed [TW-1:0] t_a, t_b, t_c, t_d;
  logic signed [SW-1:0] s_tx, s_ty;
  result_t              last_res, out_res, skid_res;

  logic [15:0]          ang_sum;
  logic [1:0]           q_in;
  logic [15:0]          r_in;
  logic signed [XW-1:0] c_sel, s_sel;

  assign en       = !sv;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // nearest quadrant and the residual angle, wrapped to 16 bits
  assign ang_sum = angle + 16'd8192;
  assign q_in    = ang_sum[15:14];
  assign r_in    = angle - {q_in, 14'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= CORDIC_GAIN;
      cy[0]   <= '0;
      cz[0]   <= {r_in, 16'b0};
      quad[0] <= q_in;
      side[0] <= '{pos_x: pos_x, pos_y: pos_y, width: width, height: height};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_turn(5'(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_turn(5'(i));
        end
        quad[i+1] <= quad[i];
        side[i+1] <= side[i];
      end
    end
  end

  always_comb begin
    case (quad[CORDIC_STEPS])
      2'd1: begin
        c_sel = -cy[CORDIC_STEPS];
        s_sel = cx[CORDIC_STEPS];
      end
      2'd2: begin
        c_sel = -cx[CORDIC_STEPS];
        s_sel = -cy[CORDIC_STEPS];
      end
      2'd3: begin
        c_sel = cy[CORDIC_STEPS];
        s_sel = -cx[CORDIC_STEPS];
      end
      default: begin
        c_sel = cx[CORDIC_STEPS];
        s_sel = cy[CORDIC_STEPS];
      end
    endcase
  end

  // round Q.30 to Q.F, multiply, sum, then round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      tc          <= CW'((c_sel + TRIG_RND) >>> TRIG_SH);
      ts          <= CW'((s_sel + TRIG_RND) >>> TRIG_SH);
      side[STG_R] <= side[CORDIC_STEPS];

      p_wc        <= PW'($signed({1'b0, side[STG_R].width}) * tc);
      p_ws        <= PW'($signed({1'b0, side[STG_R].width}) * ts);
      p_hs        <= PW'($signed({1'b0, side[STG_R].height}) * ts);
      p_hc        <= PW'($signed({1'b0, side[STG_R].height}) * tc);
      side[STG_P] <= side[STG_R];

      t_a  <= ((TW'(p_wc) <<< UP) + TERM_RND) >>> DN;
      t_b  <= ((TW'(p_ws) <<< UP) + TERM_RND) >>> DN;
      t_c  <= (((-TW'(p_hs)) <<< UP) + TERM_RND) >>> DN;
      t_d  <= ((TW'(p_hc) <<< UP) + TERM_RND) >>> DN;
      s_tx <= (SW'(side[STG_P].pos_x) <<< (F + 1))
            + ($signed(SW'({1'b0, side[STG_P].width})) <<< (F + 8))
            - (SW'(p_wc) <<< 8) + (SW'(p_hs) <<< 8);
      s_ty <= (SW'(side[STG_P].pos_y) <<< (F + 1))
            + ($signed(SW'({1'b0, side[STG_P].height})) <<< (F + 8))
            - (SW'(p_ws) <<< 8) - (SW'(p_hc) <<< 8);

      last_res.m_a     <= sat32(64'(t_a));
      last_res.m_b     <= sat32(64'(t_b));
      last_res.m_c     <= sat32(64'(t_c));
      last_res.m_d     <= sat32(64'(t_d));
      last_res.trans_x <= sat32(64'((s_tx + TRANS_RND) >>> (F + 1)));
      last_res.trans_y <= sat32(64'((s_ty + TRANS_RND) >>> (F + 1)));
    end
  end

  // output register plus one-item skid; skid full freezes the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (out_ready) begin
        sv <= 1'b0;
      end
    end else if (vld[STG_O]) begin
      if (ov && !out_ready) begin
        sv <= 1'b1;
      end else begin
        ov <= 1'b1;
      end
    end else if (out_ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (out_ready) begin
        out_res <= skid_res;
      end
    end else if (vld[STG_O]) begin
      if (ov && !out_ready) begin
        skid_res <= last_res;
      end else begin
        out_res <= last_res;
      end
    end
  end

  assign out_valid = ov;
  assign m_a       = out_res.m_a;
  assign m_b       = out_res.m_b;
  assign m_c       = out_res.m_c;
  assign m_d       = out_res.m_d;
  assign trans_x   = out_res.trans_x;
  assign trans_y   = out_res.trans_y;

endmodule

`default_nettype wire

### rtl/core/sam_checker.sv
`default_nettype none

module sam_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic signed [23:0] pos_x,
  input wire logic signed [23:0] pos_y,
  input wire logic [11:0]        width,
  input wire logic [11:0]        height,
  input wire logic [15:0]        angle,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] m_a,
  input wire logic signed [31:0] m_b,
  input wire logic signed [31:0] m_c,
  input wire logic signed [31:0] m_d,
  input wire logic signed [31:0] trans_x,
  input wire logic signed [31:0] trans_y
);

  // reset empties everything and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(m_a) && $stable(m_b)
      && $stable(m_c) && $stable(m_d) && $stable(trans_x) && $stable(trans_y))
    else $error("stalled result changed");

  // input is only closed while a result is waiting
  a_block_needs_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input closed with no result pending");

  // a full skid stays full while the receiver stalls
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !out_ready |=> !in_ready)
    else $error("input reopened during stall");

  // once a result is taken the input is open again
  a_drain_opens: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready)
    else $error("input still closed after result taken");

endmodule

bind sprite_affine_matrix sam_checker u_sam_checker (.*);

`default_nettype wire

### test/sprite_matrix_checker.sv
`default_nettype none

module sprite_matrix_checker
  import sam_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic [11:0]        width,
  input  wire logic [11:0]        height,
  input  wire logic [15:0]        angle,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [31:0] m_a,
  input  wire logic signed [31:0] m_b,
  input  wire logic signed [31:0] m_c,
  input  wire logic signed [31:0] m_d,
  input  wire logic signed [31:0] trans_x,
  input  wire logic signed [31:0] trans_y,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC     = TRIG_FRAC_DEF;
  localparam int     ROTATES  = 24;
  localparam longint GAIN_Q30 = 652032874;

  // atan(2^-i) in 2^-32 turn units
  longint atan_step [0:ROTATES-1] = '{
    536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335086, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81
  };

  result_t expected_matrices[$];
  int      mismatches  = 0;
  int      outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic longint round_half_up(input longint v, input int sh);
    if (sh == 0) return v;
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint scale_to_q14(input longint v);
    if (FRAC >= 14) return round_half_up(v, FRAC - 14);
    return v <<< (14 - FRAC);
  endfunction

  // CORDIC on the residual around the nearest quarter turn, then rotate back
  function automatic void cordic_sin_cos(input logic [15:0] ang,
                                         output longint cos_q, output longint sin_q);
    int     quad;
    longint r, z, x, y, nx, c, s;
    quad = ((int'(ang) + 8192) >> 14) & 3;
    r = longint'(ang) - longint'(quad) * 16384;
    if (r >= 32768) r -= 65536;
    z = r * 65536;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ROTATES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_step[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_step[i];
      end
      x = nx;
    end
    case (quad)
      1: begin
        c = -y;
        s = x;
      end
      2: begin
        c = -x;
        s = -y;
      end
      3: begin
        c = y;
        s = -x;
      end
      default: begin
        c = x;
        s = y;
      end
    endcase
    cos_q = round_half_up(c, 30 - FRAC);
    sin_q = round_half_up(s, 30 - FRAC);
  endfunction

  function automatic result_t predict_matrix(input logic signed [23:0] px_in,
                                             input logic signed [23:0] py_in,
                                             input logic [11:0] wd_in,
                                             input logic [11:0] ht_in,
                                             input logic [15:0] ang);
    longint  px, py, wd, ht, c, s, tx, ty;
    result_t m;
    px = longint'(px_in);
    py = longint'(py_in);
    wd = longint'(wd_in);
    ht = longint'(ht_in);
    cordic_sin_cos(ang, c, s);
    m.m_a = clamp32(scale_to_q14(wd * c));
    m.m_b = clamp32(scale_to_q14(wd * s));
    m.m_c = clamp32(scale_to_q14(-(ht * s)));
    m.m_d = clamp32(scale_to_q14(ht * c));
    // exact sum in Q.(FRAC+9): pos, half size, then the rotated half size
    tx = px * (longint'(1) <<< (FRAC + 1)) + wd * (longint'(1) <<< (FRAC + 8))
         - wd * c * 256 + ht * s * 256;
    ty = py * (longint'(1) <<< (FRAC + 1)) + ht * (longint'(1) <<< (FRAC + 8))
         - wd * s * 256 - ht * c * 256;
    m.trans_x = clamp32(round_half_up(tx, FRAC + 1));
    m.trans_y = clamp32(round_half_up(ty, FRAC + 1));
    return m;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_matrices.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_matrices.size() == 0) begin
          $error("result item with no sprite outstanding");
          mismatches++;
        end else begin
          want = expected_matrices.pop_front();
          check_field("m_a", want.m_a, m_a);
          check_field("m_b", want.m_b, m_b);
          check_field("m_c", want.m_c, m_c);
          check_field("m_d", want.m_d, m_d);
          check_field("trans_x", want.trans_x, trans_x);
          check_field("trans_y", want.trans_y, trans_y);
        end
      end
      if (in_valid && in_ready) begin
        expected_matrices.insert(expected_matrices.size(),
                                 predict_matrix(pos_x, pos_y, width, height, angle));
      end
    end
    outstanding = expected_matrices.size();
  end

endmodule

`default_nettype wire

### test/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_CYCLES   = 300;
  localparam int STALL_AFTER    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 445;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               out_ready = 1'b0;
  logic signed [23:0] pos_x     = '0;
  logic signed [23:0] pos_y     = '0;
  logic [11:0]        width     = '0;
  logic [11:0]        height    = '0;
  logic [15:0]        angle     = '0;
  logic               in_ready;
  logic               out_valid;
  logic signed [31:0] m_a, m_b, m_c, m_d, trans_x, trans_y;

  int fail_count;
  int pending;
  int sender_idle_pct   = 27;
  int receiver_idle_pct = 50;
  int items_sent        = 0;
  bit stall_done        = 1'b0;

  sprite_affine_matrix u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .width     (width),
    .height    (height),
    .angle     (angle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .m_a       (m_a),
    .m_b       (m_b),
    .m_c       (m_c),
    .m_d       (m_d),
    .trans_x   (trans_x),
    .trans_y   (trans_y)
  );

  sprite_matrix_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .width      (width),
    .height     (height),
    .angle      (angle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .m_a        (m_a),
    .m_b        (m_b),
    .m_c        (m_c),
    .m_d        (m_d),
    .trans_x    (trans_x),
    .trans_y    (trans_y),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_sprite(input logic signed [23:0] x, input logic signed [23:0] y,
                             input logic [11:0] w, input logic [11:0] h,
                             input logic [15:0] a);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    width    <= w;
    height   <= h;
    angle    <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [23:0] extreme_pos();
    case ($urandom_range(0, 3))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  task automatic send_random_sprite();
    int                 kind;
    logic signed [23:0] x, y;
    logic [11:0]        w, h;
    logic [15:0]        a;
    kind = $urandom_range(0, 9);
    x = 24'($urandom);
    y = 24'($urandom);
    w = 12'($urandom);
    h = 12'($urandom);
    a = 16'($urandom);
    case (kind)
      6: a = 16'(8192 + 16384 * $urandom_range(0, 3) + $urandom_range(0, 8) - 4);
      7: begin
        w = 12'($urandom_range(0, 3));
        h = 12'($urandom_range(0, 3));
      end
      8: begin
        x = extreme_pos();
        y = extreme_pos();
        w = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        h = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      end
      // around multiples of an eighth turn, wrapping below zero
      9: a = 16'(8192 * $urandom_range(0, 7) + $urandom_range(0, 2) - 1);
      default: ;
    endcase
    send_sprite(x, y, w, h, a);
  endtask

  // receiver: random backpressure plus one long hold-off to fill the pipe
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && !stall_done && items_sent >= STALL_AFTER) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_sprite(24'h000000, 24'h000000, 12'd0, 12'd0, 16'd0);
    send_sprite(24'h7FFFFF, 24'h7FFFFF, 12'hFFF, 12'hFFF, 16'd0);
    send_sprite(24'h800000, 24'h800000, 12'hFFF, 12'hFFF, 16'd16384);
    send_sprite(24'h800000, 24'h7FFFFF, 12'hFFF, 12'd0, 16'd32768);
    send_sprite(24'h7FFFFF, 24'h800000, 12'd0, 12'hFFF, 16'd49152);
    send_sprite(24'hFFFFFF, 24'h000100, 12'd64, 12'd32, 16'd8191);
    send_sprite(24'h000100, 24'hFFFFFF, 12'd64, 12'd32, 16'd8192);
    send_sprite(24'h001000, 24'h002000, 12'd100, 12'd50, 16'd24575);
    send_sprite(24'h001000, 24'h002000, 12'd100, 12'd50, 16'd24576);
    send_sprite(24'hFF0000, 24'h00FF00, 12'd17, 12'd33, 16'd40959);
    send_sprite(24'hFF0000, 24'h00FF00, 12'd17, 12'd33, 16'd40960);
    send_sprite(24'h123456, 24'hEDCBA9, 12'd255, 12'd511, 16'd57343);
    send_sprite(24'h123456, 24'hEDCBA9, 12'd255, 12'd511, 16'd57344);
    send_sprite(24'h7FFFFF, 24'h7FFFFF, 12'hFFF, 12'hFFF, 16'd65535);
    send_sprite(24'h800000, 24'h800000, 12'hFFF, 12'hFFF, 16'd1);
    send_sprite(24'h555555, 24'hAAAAAA, 12'h555, 12'hAAA, 16'h5555);
    send_sprite(24'hAAAAAA, 24'h555555, 12'hAAA, 12'h555, 16'hAAAA);
    send_sprite(24'h000001, 24'hFFFFFF, 12'd1, 12'd1, 16'd4096);

    for (int i = 0; i < PHASE_ITEMS; i++) send_random_sprite();
    sender_idle_pct   = 50;
    receiver_idle_pct = 27;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_sprite();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_sprite();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
